>>> rtl/core/header_length_checksum_deframer_defines.svh
// assertion macros for the header length checksum deframer
`ifndef HEADER_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH
`define HEADER_LENGTH_CHECKSUM_DEFRAMER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HLCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hlcd assertion failed");
`define HLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hlcd assertion failed");
`else
`define HLCD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/core/hlcd_pkg.sv
// shared types and constants for the header length checksum deframer
`timescale 1ns / 1ps
package hlcd_pkg;

    localparam int BUFFER_BYTES = 64;
    // longest body is limit length plus four bytes
    localparam int COUNT_W = $clog2(BUFFER_BYTES + 8);
    localparam int INDEX_W = 7;
    localparam int CMP_W   = 10;
    localparam logic [7:0] LEN_LIMIT = 8'(BUFFER_BYTES + 3);
    localparam logic [CMP_W-1:0] BODY_EXTRA = CMP_W'(4);

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_FIRST  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SECOND = 1'b1;

    localparam logic [7:0] HEADER_FIRST_RESET  = 8'd170;
    localparam logic [7:0] HEADER_SECOND_RESET = 8'd85;

    typedef enum logic [1:0] {
        PH_HUNT1 = 2'd0,
        PH_HUNT2 = 2'd1,
        PH_BODY  = 2'd2
    } phase_t;

    typedef struct packed {
        logic               emit;
        logic [7:0]         data;
        logic [INDEX_W-1:0] index;
        logic               last;
        logic               good;
        logic               abort;
    } hlcd_result_t;

endpackage

>>> rtl/core/hlcd_frame_fsm.sv
// frame state machine: header hunt, body count, length check and running sum
`timescale 1ns / 1ps
module hlcd_frame_fsm
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           data,
    input  logic [7:0]           header_first,
    input  logic [7:0]           header_second,
    output hlcd_pkg::hlcd_result_t result
);

    hlcd_pkg::phase_t             phase_reg, phase_next;
    logic [hlcd_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [7:0]                   len_reg, len_next;
    logic [7:0]                   sum_reg, sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hlcd_pkg::PH_HUNT1;
            count_reg <= '0;
            len_reg   <= '0;
            sum_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
        end
    end

    logic [7:0]                   len_eff;
    logic [7:0]                   sum_new;
    logic [hlcd_pkg::COUNT_W-1:0] count_inc;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        len_eff    = (count_reg == '0) ? data : len_reg;
        sum_new    = sum_reg + data;
        count_inc  = count_reg + 1'b1;
        result     = '0;
        result.data  = data;
        result.index = hlcd_pkg::INDEX_W'(count_reg);
        case (phase_reg)
            hlcd_pkg::PH_HUNT2:
            begin
                if (data == header_second)
                begin
                    phase_next = hlcd_pkg::PH_BODY;
                    count_next = '0;
                    sum_next   = '0;
                end
            end
            hlcd_pkg::PH_BODY:
            begin
                result.emit = 1'b1;
                len_next    = len_eff;
                sum_next    = sum_new;
                if (len_eff > hlcd_pkg::LEN_LIMIT)
                begin
                    result.last  = 1'b1;
                    result.abort = 1'b1;
                    phase_next   = hlcd_pkg::PH_HUNT1;
                    count_next   = '0;
                end
                else if (hlcd_pkg::CMP_W'(count_inc) >=
                         hlcd_pkg::CMP_W'(len_eff) + hlcd_pkg::BODY_EXTRA)
                begin
                    result.last = 1'b1;
                    result.good = (sum_new == 8'd0);
                    phase_next  = hlcd_pkg::PH_HUNT1;
                    count_next  = '0;
                end
                else
                begin
                    count_next = count_inc;
                end
            end
            default:
            begin
                phase_next = (data == header_first) ? hlcd_pkg::PH_HUNT2
                                                    : hlcd_pkg::PH_HUNT1;
            end
        endcase
    end

endmodule

>>> rtl/core/header_length_checksum_deframer.sv
// top level of the header length checksum deframer
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | in        | in_valid/in_stall  | rx_byte
//  out     | out       | out_valid/out_stall| body_byte body_index is_last frame_good
//          |           |                    | frame_abort
//  cfg     | in        | cfg_valid/cfg_ready| cfg_index cfg_data
//
// one word per cycle sustained while out_stall is low; a word is held in the input register and
// its result is then registered in the output register
// the frame state advances once per word as it leaves the input register
// rst_n is asynchronous, active low; headers return to 170 and 85, hunt restarts
// out_stall holds the output register, and in_stall rises only when the input
// register is full and the output register cannot take a new word
`timescale 1ns / 1ps
`include "header_length_checksum_deframer_defines.svh"
module header_length_checksum_deframer
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       rx_byte,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       body_byte,
    output logic [hlcd_pkg::INDEX_W-1:0]     body_index,
    output logic                             is_last,
    output logic                             frame_good,
    output logic                             frame_abort,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [hlcd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                       cfg_data
);

    // configuration registers, always ready
    logic [7:0] header_first_reg;
    logic [7:0] header_second_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_first_reg  <= hlcd_pkg::HEADER_FIRST_RESET;
            header_second_reg <= hlcd_pkg::HEADER_SECOND_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                hlcd_pkg::REG_HEADER_FIRST:  header_first_reg  <= cfg_data;
                hlcd_pkg::REG_HEADER_SECOND: header_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_free;
    logic       advance;

    // output register can take a word when empty or being drained
    assign out_free = !out_valid || !out_stall;
    // word in the input register is processed this cycle
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // frame logic between the two registers
    hlcd_pkg::hlcd_result_t result;

    hlcd_frame_fsm u_fsm
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .data          (in_byte_reg),
        .header_first  (header_first_reg),
        .header_second (header_second_reg),
        .result        (result)
    );

    // output register; header and hunt bytes leave no word here
    logic out_valid_reg;
    hlcd_pkg::hlcd_result_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && result.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.emit)
        begin
            out_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign body_byte   = out_reg.data;
    assign body_index  = out_reg.index;
    assign is_last     = out_reg.last;
    assign frame_good  = out_reg.good;
    assign frame_abort = out_reg.abort;

    // checks
    `HLCD_ASSERT_IMP(a_abort_ends_bad, clk, rst_n, out_valid && frame_abort, is_last && !frame_good)
    `HLCD_ASSERT_IMP(a_good_is_last, clk, rst_n, out_valid && frame_good, is_last)
    `HLCD_ASSERT_IMP(a_stall_needs_word, clk, rst_n, in_stall, in_valid_reg && out_valid)
    `HLCD_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_valid && !in_stall, in_valid_reg)

endmodule

>>> tb/hlcd_frame_checker.sv
// checker for the header length checksum deframer: predicts body words and compares them
`timescale 1ns / 1ps
module hlcd_frame_checker
    import hlcd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic [7:0]             rx_byte,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [7:0]             body_byte,
    input  logic [INDEX_W-1:0]     body_index,
    input  logic                   is_last,
    input  logic                   frame_good,
    input  logic                   frame_abort,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    output int                     mismatch_count,
    output int                     words_pending,
    output int                     words_checked,
    output int                     good_frames,
    output int                     aborted_frames
);

    typedef struct packed {
        logic [7:0]         data;
        logic [INDEX_W-1:0] index;
        logic               last;
        logic               good;
        logic               abort;
    } body_word_t;

    body_word_t  expected_words[$];
    logic [7:0]  hdr_first;
    logic [7:0]  hdr_second;
    phase_t      phase;
    logic [15:0] body_count;
    logic [7:0]  frame_len;
    logic [7:0]  body_sum;
    int          fails;
    int          checked;
    int          n_good;
    int          n_abort;

    // advance the frame state by one received byte, queue the body word it yields
    task automatic deframe_byte(input logic [7:0] b);
        body_word_t  w;
        logic [15:0] idx;
        case (phase)
            PH_HUNT2:
            begin
                if (b == hdr_second)
                begin
                    phase      = PH_BODY;
                    body_count = '0;
                    body_sum   = '0;
                end
            end
            PH_BODY:
            begin
                idx = body_count;
                if (idx == 0)
                    frame_len = b;
                body_sum = body_sum + b;
                w.data  = b;
                w.index = idx[INDEX_W-1:0];
                w.last  = 1'b0;
                w.good  = 1'b0;
                w.abort = 1'b0;
                if (int'(frame_len) > BUFFER_BYTES + 3)
                begin
                    w.last     = 1'b1;
                    w.abort    = 1'b1;
                    phase      = PH_HUNT1;
                    body_count = '0;
                end
                else
                begin
                    body_count = idx + 16'd1;
                    if (int'(body_count) >= int'(frame_len) + 4)
                    begin
                        w.last     = 1'b1;
                        w.good     = (body_sum == 8'd0);
                        phase      = PH_HUNT1;
                        body_count = '0;
                    end
                end
                expected_words.push_back(w);
            end
            default:
                phase = (b == hdr_first) ? PH_HUNT2 : PH_HUNT1;
        endcase
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        body_word_t got;
        body_word_t want;
        if (!rst_n)
        begin
            hdr_first  = HEADER_FIRST_RESET;
            hdr_second = HEADER_SECOND_RESET;
            phase      = PH_HUNT1;
            body_count = '0;
            frame_len  = '0;
            body_sum   = '0;
            expected_words.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_HEADER_FIRST)
                    hdr_first = cfg_data;
                else if (cfg_index == REG_HEADER_SECOND)
                    hdr_second = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                got.data  = body_byte;
                got.index = body_index;
                got.last  = is_last;
                got.good  = frame_good;
                got.abort = frame_abort;
                if (expected_words.size() == 0)
                begin
                    fails++;
                    $display("%0t: word mismatch, expected none, actual byte %0d index %0d",
                             $time, got.data, got.index);
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("body_byte", want.data, got.data);
                    check_field("body_index", want.index, got.index);
                    check_field("is_last", want.last, got.last);
                    check_field("frame_good", want.good, got.good);
                    check_field("frame_abort", want.abort, got.abort);
                    checked++;
                    if (want.good)
                        n_good++;
                    if (want.abort)
                        n_abort++;
                end
            end
            if (in_valid && !in_stall)
                deframe_byte(rx_byte);
        end
        mismatch_count <= fails;
        words_pending  <= expected_words.size();
        words_checked  <= checked;
        good_frames    <= n_good;
        aborted_frames <= n_abort;
    end

endmodule

>>> tb/tb_header_length_checksum_deframer.sv
// testbench top for the header length checksum deframer: byte stimulus, header writes, verdict
`timescale 1ns / 1ps
module tb_header_length_checksum_deframer;
    import hlcd_pkg::*;

    localparam int LONG_HOLD_CYCLES = 160;   // output held off long enough to back up the input
    localparam int PHASE_BYTES      = 155;   // random bytes per header setting
    localparam int SETTLE_CYCLES    = 6;     // margin for the pipeline to empty after the last word

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    logic [7:0]             rx_byte   = 8'd0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [7:0]             body_byte;
    logic [INDEX_W-1:0]     body_index;
    logic                   is_last;
    logic                   frame_good;
    logic                   frame_abort;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_HEADER_FIRST;
    logic [7:0]             cfg_data  = 8'd0;

    int mismatch_count;
    int words_pending;
    int words_checked;
    int good_frames;
    int aborted_frames;

    // stimulus knobs shared between the sender and the receiver process
    bit idle_on       = 1'b1;
    bit long_hold_req = 1'b0;
    int bytes_sent    = 0;

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    header_length_checksum_deframer u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .body_byte  (body_byte),
        .body_index (body_index),
        .is_last    (is_last),
        .frame_good (frame_good),
        .frame_abort(frame_abort),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    hlcd_frame_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .body_byte     (body_byte),
        .body_index    (body_index),
        .is_last       (is_last),
        .frame_good    (frame_good),
        .frame_abort   (frame_abort),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatch_count(mismatch_count),
        .words_pending (words_pending),
        .words_checked (words_checked),
        .good_frames   (good_frames),
        .aborted_frames(aborted_frames)
    );

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                long_hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge clk);
                out_stall <= 0;
            end
        end
    end

    // offer one word, maybe after a random gap, and hold it until it is taken
    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
    endtask

    // full frame: headers, length, two command bytes, payload, checksum
    // a bad frame gets its checksum knocked off zero by a random nonzero amount
    task automatic send_frame(input logic [7:0] hf, input logic [7:0] hs, input int len,
                              input bit good);
        logic [7:0] sum;
        logic [7:0] b;
        sum = 8'(len);
        send_byte(hf);
        send_byte(hs);
        send_byte(8'(len));
        // an oversized length ends the frame right there
        if (len > BUFFER_BYTES + 3)
            return;
        for (int i = 0; i < len + 2; i++)
        begin
            b   = 8'($urandom);
            sum = sum + b;
            send_byte(b);
        end
        b = -sum;
        if (!good)
            b = b + 8'($urandom_range(1, 255));
        send_byte(b);
    endtask

    // line noise leans toward the header bytes so that false starts are common
    function automatic logic [7:0] noise_byte(input logic [7:0] hf, input logic [7:0] hs);
        case ($urandom_range(0, 3))
            0:       return hf;
            1:       return hs;
            default: return 8'($urandom);
        endcase
    endfunction

    // wait until every expected word is out, then let the pipeline empty
    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // headers change only with the block idle
    task automatic set_headers(input logic [7:0] hf, input logic [7:0] hs);
        drain_block();
        write_reg(REG_HEADER_FIRST, hf);
        write_reg(REG_HEADER_SECOND, hs);
    endtask

    // mostly well-formed frames with random content, some noise, oversized lengths and cut-off frames
    task automatic run_phase(input logic [7:0] hf, input logic [7:0] hs, input int n_bytes);
        int stop_at;
        int len;
        int pick;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                len = BUFFER_BYTES + 3;
            else if (pick < 10)
                len = $urandom_range(BUFFER_BYTES + 4, 255);
            else
                len = $urandom_range(0, 12);
            repeat ($urandom_range(0, 2)) send_byte(noise_byte(hf, hs));
            if ($urandom_range(0, 99) < 8)
            begin
                // cut-off frame: the next header gets swallowed as body
                send_byte(hf);
                send_byte(hs);
                send_byte(8'($urandom_range(0, 12)));
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
            end
            else
                send_frame(hf, hs, len, $urandom_range(0, 4) != 0);
        end
    endtask

    initial
    begin
        logic [7:0] hf;
        logic [7:0] hs;

        // hold reset, then release it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset headers, byte extremes, false starts
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(HEADER_FIRST_RESET);
        // a repeated first header and a stray byte are dropped while waiting
        send_byte(HEADER_FIRST_RESET);
        send_byte(8'h13);
        send_byte(HEADER_SECOND_RESET);
        // zero length frame, body sum comes to zero
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(8'h81);
        // length just over the limit aborts on the length byte
        send_byte(HEADER_FIRST_RESET);
        send_byte(HEADER_SECOND_RESET);
        send_byte(8'(BUFFER_BYTES + 4));
        // largest length byte aborts as well
        send_byte(HEADER_FIRST_RESET);
        send_byte(HEADER_SECOND_RESET);
        send_byte(8'hFF);
        // one payload byte with a wrong checksum
        send_byte(HEADER_FIRST_RESET);
        send_byte(HEADER_SECOND_RESET);
        send_byte(8'h01);
        send_byte(8'h7F);
        send_byte(8'h00);
        send_byte(8'h55);
        send_byte(8'h00);

        // longest legal frame, then random traffic on reset headers
        send_frame(HEADER_FIRST_RESET, HEADER_SECOND_RESET, BUFFER_BYTES + 3, 1'b1);
        run_phase(HEADER_FIRST_RESET, HEADER_SECOND_RESET, PHASE_BYTES);

        // header extremes; the output is held off while a long frame streams in
        set_headers(8'h00, 8'hFF);
        long_hold_req = 1'b1;
        send_frame(8'h00, 8'hFF, 30, 1'b1);
        run_phase(8'h00, 8'hFF, PHASE_BYTES);

        set_headers(8'hFF, 8'h00);
        run_phase(8'hFF, 8'h00, PHASE_BYTES);

        // equal headers: the second copy of the sync byte opens the body
        set_headers(8'h5A, 8'h5A);
        run_phase(8'h5A, 8'h5A, PHASE_BYTES);

        hf = 8'($urandom);
        hs = 8'($urandom);
        set_headers(hf, hs);
        run_phase(hf, hs, PHASE_BYTES);

        // closing stretch at full rate on both sides
        idle_on = 1'b0;
        set_headers(HEADER_FIRST_RESET, HEADER_SECOND_RESET);
        run_phase(HEADER_FIRST_RESET, HEADER_SECOND_RESET, PHASE_BYTES);
        drain_block();

        $display("run covered %0d bytes in, %0d body words checked", bytes_sent, words_checked);
        $display("%0d frames closed good, %0d aborted, over six header settings",
                 good_frames, aborted_frames);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
